@@ hdl/segment_obstacle_clearance_unit_macros.svh @@
// Assertion macros for the segment obstacle clearance unit.
// Included by the modules that check their own sequencing; needs clk and rst_n in scope.
`ifndef SEGMENT_OBSTACLE_CLEARANCE_UNIT_MACROS_SVH
`define SEGMENT_OBSTACLE_CLEARANCE_UNIT_MACROS_SVH
`ifndef SYNTH
`define SOCU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SOCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SOCU_ASSERT_NOW(lbl, ante, cons, msg)
`define SOCU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/socu_pkg.sv @@
// Shared constants and types of the segment obstacle clearance unit.
// No dependencies; imported by every module of the block.
package socu_pkg;

    localparam int COORD_WIDTH_DEF = 18;
    localparam int MODE_W          = 2;
    localparam int ADDR_W          = 5;
    localparam int APB_DATA_W      = 32;
    localparam int OUT_DATA_W      = 8;

    localparam logic [MODE_W-1:0] MODE_MORE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAST = 2'd1;

    typedef enum logic [2:0] {
        REG_START_X,
        REG_START_Y,
        REG_FINISH_X,
        REG_FINISH_Y,
        REG_CLEARANCE
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_HALF,
        SH_HALF_DBL,
        SH_FULL
    } shift_sel_t;

    typedef struct packed {
        logic       issue;
        logic       clear;
        logic       negate;
        shift_sel_t shift;
    } mac_cmd_t;

endpackage

@@ hdl/socu_regs.sv @@
// Configuration register file: path end points and clearance, APB write and read.
// Depends on socu_pkg.
module socu_regs #(
    parameter int COORD_WIDTH = socu_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [socu_pkg::ADDR_W-1:0]     paddr,
    input  logic [socu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [socu_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [COORD_WIDTH-1:0]          start_x,
    output logic [COORD_WIDTH-1:0]          start_y,
    output logic [COORD_WIDTH-1:0]          finish_x,
    output logic [COORD_WIDTH-1:0]          finish_y,
    output logic [COORD_WIDTH-2:0]          clearance
);
    import socu_pkg::*;

    localparam int W = COORD_WIDTH;

    logic [W-1:0] start_x_reg;
    logic [W-1:0] start_y_reg;
    logic [W-1:0] finish_x_reg;
    logic [W-1:0] finish_y_reg;
    logic [W-2:0] clearance_reg;
    logic         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            finish_x_reg  <= '0;
            finish_y_reg  <= '0;
            clearance_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[ADDR_W-1:2])
                REG_START_X:   start_x_reg   <= pwdata[W-1:0];
                REG_START_Y:   start_y_reg   <= pwdata[W-1:0];
                REG_FINISH_X:  finish_x_reg  <= pwdata[W-1:0];
                REG_FINISH_Y:  finish_y_reg  <= pwdata[W-1:0];
                REG_CLEARANCE: clearance_reg <= pwdata[W-2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[ADDR_W-1:2])
            REG_START_X:   prdata = APB_DATA_W'(start_x_reg);
            REG_START_Y:   prdata = APB_DATA_W'(start_y_reg);
            REG_FINISH_X:  prdata = APB_DATA_W'(finish_x_reg);
            REG_FINISH_Y:  prdata = APB_DATA_W'(finish_y_reg);
            REG_CLEARANCE: prdata = APB_DATA_W'(clearance_reg);
            default:       prdata = '0;
        endcase
    end

    assign start_x   = start_x_reg;
    assign start_y   = start_y_reg;
    assign finish_x  = finish_x_reg;
    assign finish_y  = finish_y_reg;
    assign clearance = clearance_reg;

endmodule

@@ hdl/socu_mac.sv @@
// Shared multiply-accumulate unit: registered unsigned product, then shifted signed accumulate.
// Depends on socu_pkg; driven by socu_ctrl.
module socu_mac #(
    parameter int COORD_WIDTH = socu_pkg::COORD_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  socu_pkg::mac_cmd_t         cmd,
    input  logic [COORD_WIDTH:0]       op_a,
    input  logic [COORD_WIDTH:0]       op_b,
    output logic [4*COORD_WIDTH+4:0]   acc
);
    import socu_pkg::*;

    localparam int H     = COORD_WIDTH + 1;
    localparam int ACC_W = 4 * H + 1;

    logic [2*H-1:0]   prod_reg;
    logic             acc_en_reg;
    logic             clr_reg;
    logic             neg_reg;
    shift_sel_t       sh_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] prod_ext;
    logic [ACC_W-1:0] shifted;
    logic [ACC_W-1:0] term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_en_reg <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            prod_reg <= op_a * op_b;
            clr_reg  <= cmd.clear;
            neg_reg  <= cmd.negate;
            sh_reg   <= cmd.shift;
        end
        if (acc_en_reg)
        begin
            acc_reg <= (clr_reg ? '0 : acc_reg) + term;
        end
    end

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        case (sh_reg)
            SH_NONE:     shifted = prod_ext;
            SH_HALF:     shifted = prod_ext << H;
            SH_HALF_DBL: shifted = prod_ext << (H + 1);
            SH_FULL:     shifted = prod_ext << (2 * H);
            default:     shifted = prod_ext;
        endcase
        term = neg_reg ? (~shifted + 1'b1) : shifted;
    end

    assign acc = acc_reg;

endmodule

@@ hdl/socu_ctrl.sv @@
// Step sequencer: operand selection, intermediate store, decision and result word.
// Depends on socu_pkg and the assertion macro header; drives socu_mac.
`include "segment_obstacle_clearance_unit_macros.svh"
module socu_ctrl #(
    parameter int COORD_WIDTH = socu_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [COORD_WIDTH-1:0]      start_x,
    input  logic [COORD_WIDTH-1:0]      start_y,
    input  logic [COORD_WIDTH-1:0]      finish_x,
    input  logic [COORD_WIDTH-1:0]      finish_y,
    input  logic [COORD_WIDTH-2:0]      clearance,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [socu_pkg::MODE_W-1:0] mode,
    input  logic [COORD_WIDTH-1:0]      obstacle_x,
    input  logic [COORD_WIDTH-1:0]      obstacle_y,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        path_clear,
    output socu_pkg::mac_cmd_t          mac_cmd,
    output logic [COORD_WIDTH:0]        op_a,
    output logic [COORD_WIDTH:0]        op_b,
    input  logic [4*COORD_WIDTH+4:0]    acc
);
    import socu_pkg::*;

    localparam int W          = COORD_WIDTH;
    localparam int H          = W + 1;
    localparam int STEP_W     = 4;
    localparam int STEP_COUNT = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_RX,
        OP_RY,
        OP_DX,
        OP_DY,
        OP_CLR,
        OP_C_LO,
        OP_C_HI,
        OP_TT_LO,
        OP_TT_HI,
        OP_DD_LO,
        OP_DD_HI
    } opnd_t;

    typedef enum logic [2:0] {
        STO_NONE,
        STO_P,
        STO_C,
        STO_DD,
        STO_TT,
        STO_LHS
    } store_t;

    typedef struct packed {
        logic       issue;
        logic       clear;
        logic       extra_neg;
        shift_sel_t sh;
        opnd_t      opa;
        opnd_t      opb;
        store_t     sto;
        logic       decide;
    } step_t;

    // Each product passes through the MAC product register and then its accumulator before it can be stored.
    function automatic step_t step_entry(input logic [STEP_W-1:0] s);
        step_t e;
        begin
            e        = '0;
            e.sh     = SH_NONE;
            e.opa    = OP_RX;
            e.opb    = OP_RX;
            e.sto    = STO_NONE;
            e.issue  = 1'b1;
            unique case (s)
                4'd0:
                begin
                    e.opa = OP_RX; e.opb = OP_DX; e.clear = 1'b1;
                end
                4'd1:
                begin
                    e.opa = OP_RY; e.opb = OP_DY;
                end
                4'd2:
                begin
                    e.opa = OP_RX; e.opb = OP_DY; e.clear = 1'b1;
                end
                4'd3:
                begin
                    e.opa = OP_RY; e.opb = OP_DX; e.extra_neg = 1'b1; e.sto = STO_P;
                end
                4'd4:
                begin
                    e.opa = OP_DX; e.opb = OP_DX; e.clear = 1'b1;
                end
                4'd5:
                begin
                    e.opa = OP_DY; e.opb = OP_DY; e.sto = STO_C;
                end
                4'd6:
                begin
                    e.opa = OP_CLR; e.opb = OP_CLR; e.clear = 1'b1;
                end
                4'd7:
                begin
                    e.opa = OP_C_LO; e.opb = OP_C_LO; e.clear = 1'b1; e.sto = STO_DD;
                end
                4'd8:
                begin
                    e.opa = OP_C_HI; e.opb = OP_C_LO; e.sh = SH_HALF_DBL; e.sto = STO_TT;
                end
                4'd9:
                begin
                    e.opa = OP_C_HI; e.opb = OP_C_HI; e.sh = SH_FULL;
                end
                4'd10:
                begin
                    e.opa = OP_TT_LO; e.opb = OP_DD_LO; e.clear = 1'b1;
                end
                4'd11:
                begin
                    e.opa = OP_TT_LO; e.opb = OP_DD_HI; e.sh = SH_HALF; e.sto = STO_LHS;
                end
                4'd12:
                begin
                    e.opa = OP_TT_HI; e.opb = OP_DD_LO; e.sh = SH_HALF;
                end
                4'd13:
                begin
                    e.opa = OP_TT_HI; e.opb = OP_DD_HI; e.sh = SH_FULL;
                end
                4'd14:
                begin
                    e.issue = 1'b0;
                end
                default:
                begin
                    e.issue  = 1'b0;
                    e.decide = 1'b1;
                end
            endcase
            return e;
        end
    endfunction

    function automatic logic [H-1:0] mag_of(input logic [H-1:0] v);
        begin
            return v[H-1] ? (~v + 1'b1) : v;
        end
    endfunction

    state_t            state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              blocked_reg;
    logic              last_reg;
    logic              m_valid_reg;
    logic              path_clear_reg;

    logic [H-1:0]      rx_reg;
    logic [H-1:0]      ry_reg;
    logic [H-1:0]      dx_reg;
    logic [H-1:0]      dy_reg;
    logic [2*H:0]      p_reg;
    logic [2*H-1:0]    cmag_reg;
    logic [2*H-1:0]    dd_reg;
    logic [2*H-1:0]    tt_reg;
    logic [4*H-1:0]    lhs_reg;

    step_t             cur;
    logic              run;
    logic              accept;
    logic              out_load;
    logic [2*H:0]      c_s;
    logic [2*H:0]      c_neg;
    logic [2*H-1:0]    c_mag;
    logic              p_pos;
    logic              p_lt;
    logic              c_lt;
    logic              blk;

    function automatic logic [H:0] pick(input opnd_t sel);
        begin
            case (sel)
                OP_RX:    return {rx_reg[H-1], mag_of(rx_reg)};
                OP_RY:    return {ry_reg[H-1], mag_of(ry_reg)};
                OP_DX:    return {dx_reg[H-1], mag_of(dx_reg)};
                OP_DY:    return {dy_reg[H-1], mag_of(dy_reg)};
                OP_CLR:   return {1'b0, H'(clearance)};
                OP_C_LO:  return {1'b0, cmag_reg[H-1:0]};
                OP_C_HI:  return {1'b0, cmag_reg[2*H-1:H]};
                OP_TT_LO: return {1'b0, tt_reg[H-1:0]};
                OP_TT_HI: return {1'b0, tt_reg[2*H-1:H]};
                OP_DD_LO: return {1'b0, dd_reg[H-1:0]};
                OP_DD_HI: return {1'b0, dd_reg[2*H-1:H]};
                default:  return '0;
            endcase
        end
    endfunction

    logic [H:0] pa;
    logic [H:0] pb;

    assign cur      = step_entry(step_reg);
    assign run      = (state_reg == ST_RUN);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);

    always_comb
    begin
        pa = pick(cur.opa);
        pb = pick(cur.opb);
        op_a = pa[H-1:0];
        op_b = pb[H-1:0];
        mac_cmd.issue  = run && cur.issue;
        mac_cmd.clear  = cur.clear;
        mac_cmd.negate = pa[H] ^ pb[H] ^ cur.extra_neg;
        mac_cmd.shift  = cur.sh;
    end

    always_comb
    begin
        c_s   = acc[2*H:0];
        c_neg = ~c_s + 1'b1;
        c_mag = c_s[2*H] ? c_neg[2*H-1:0] : c_s[2*H-1:0];
        p_pos = !p_reg[2*H] && (|p_reg);
        p_lt  = $signed(p_reg) < $signed({1'b0, dd_reg});
        c_lt  = lhs_reg < acc[4*H-1:0];
        blk   = p_pos && p_lt && c_lt;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_reg <= {obstacle_x[W-1], obstacle_x} - {start_x[W-1], start_x};
            ry_reg <= {obstacle_y[W-1], obstacle_y} - {start_y[W-1], start_y};
            dx_reg <= {finish_x[W-1], finish_x} - {start_x[W-1], start_x};
            dy_reg <= {finish_y[W-1], finish_y} - {start_y[W-1], start_y};
        end
        if (run)
        begin
            case (cur.sto)
                STO_P:   p_reg    <= acc[2*H:0];
                STO_C:   cmag_reg <= c_mag;
                STO_DD:  dd_reg   <= acc[2*H-1:0];
                STO_TT:  tt_reg   <= acc[2*H-1:0];
                STO_LHS: lhs_reg  <= acc[4*H-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            blocked_reg    <= 1'b0;
            last_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            path_clear_reg <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !out_load)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg <= (mode == MODE_LAST);
                        step_reg <= '0;
                        if (mode == MODE_MORE || mode == MODE_LAST)
                        begin
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (cur.decide)
                    begin
                        blocked_reg <= blocked_reg | blk;
                        state_reg   <= last_reg ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    if (out_load)
                    begin
                        path_clear_reg <= !blocked_reg;
                        m_valid_reg    <= 1'b1;
                        blocked_reg    <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign path_clear = path_clear_reg;

    `SOCU_ASSERT_NEXT(a_run_start, accept && (mode == MODE_MORE || mode == MODE_LAST), state_reg == ST_RUN && step_reg == '0, "obstacle word did not start the step sequence")
    `SOCU_ASSERT_NEXT(a_flag_clear, out_load, !blocked_reg && m_valid_reg, "result load left the blocked flag set")
    `SOCU_ASSERT_NOW(a_valid_src, $rose(m_valid_reg), $past(state_reg == ST_FIN), "result word raised outside the finish state")
    `SOCU_ASSERT_NOW(a_step_range, run && step_reg == STEP_W'(STEP_COUNT - 1), cur.decide, "step counter past the decision step")

endmodule

@@ hdl/segment_obstacle_clearance_unit.sv @@
// Top level of the segment obstacle clearance unit: register file, sequencer, shared MAC.
// Depends on socu_pkg, socu_regs, socu_mac and socu_ctrl.
//
//   port group  | role      | contents
//   ------------+-----------+------------------------------------------------------
//   s_t*        | in words  | tuser: mode; tdata: obstacle_x, obstacle_y
//   m_t*        | out words | tdata: path_clear
//   p*          | APB slave | start_x, start_y, finish_x, finish_y, clearance
//
// An obstacle word (mode 0 or 1) runs sixteen sequencer steps that drive the single
// multiply-accumulate unit; the next word is taken only after the decision step.
// After a last-obstacle word the finish state loads the result, as it does for a list query.
// rst_n clears the registers, the blocked flag and the sequencer; no clearing pass is needed.
// A result word waiting on m_tready holds the sequencer in its finish state.
module segment_obstacle_clearance_unit #(
    parameter int COORD_WIDTH = socu_pkg::COORD_WIDTH_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [socu_pkg::ADDR_W-1:0]                   paddr,
    input  logic [socu_pkg::APB_DATA_W-1:0]               pwdata,
    output logic [socu_pkg::APB_DATA_W-1:0]               prdata,
    output logic                                          pready,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // obstacle_x, obstacle_y, zero padding
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]            s_tdata,
    // mode
    input  logic [socu_pkg::MODE_W-1:0]                   s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // path_clear, zero padding
    output logic [socu_pkg::OUT_DATA_W-1:0]               m_tdata
);
    import socu_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int H     = W + 1;
    localparam int ACC_W = 4 * H + 1;

    logic [W-1:0]     start_x;
    logic [W-1:0]     start_y;
    logic [W-1:0]     finish_x;
    logic [W-1:0]     finish_y;
    logic [W-2:0]     clearance;
    logic             path_clear;
    mac_cmd_t         mac_cmd;
    logic [H-1:0]     op_a;
    logic [H-1:0]     op_b;
    logic [ACC_W-1:0] acc;

    socu_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start_x   (start_x),
        .start_y   (start_y),
        .finish_x  (finish_x),
        .finish_y  (finish_y),
        .clearance (clearance)
    );

    socu_ctrl #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_x    (start_x),
        .start_y    (start_y),
        .finish_x   (finish_x),
        .finish_y   (finish_y),
        .clearance  (clearance),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .mode       (s_tuser),
        .obstacle_x (s_tdata[W-1:0]),
        .obstacle_y (s_tdata[2*W-1:W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .path_clear (path_clear),
        .mac_cmd    (mac_cmd),
        .op_a       (op_a),
        .op_b       (op_b),
        .acc        (acc)
    );

    socu_mac #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    assign m_tdata = {{(OUT_DATA_W-1){1'b0}}, path_clear};

endmodule

@@ test/segment_obstacle_clearance_check.sv @@
// Checker for segment_obstacle_clearance_unit: follows the APB register writes and both word
// streams, works out each path_clear answer and compares it with the word the block returns.
// Depends on socu_pkg; instantiated beside the block by segment_obstacle_clearance_unit_test.
module segment_obstacle_clearance_check #(
    parameter int COORD_WIDTH = socu_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [socu_pkg::ADDR_W-1:0]           paddr,
    input  logic [socu_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic                                  pready,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    // obstacle_x, obstacle_y, zero padding
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // mode
    input  logic [socu_pkg::MODE_W-1:0]           s_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    // path_clear, zero padding
    input  logic [socu_pkg::OUT_DATA_W-1:0]       m_tdata,
    output int                                    failures,
    output int                                    pending,
    output int                                    answers,
    output int                                    blocked_answers
);

    import socu_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 finish_x;
    coord_t                 finish_y;
    logic [COORD_WIDTH-2:0] clearance;
    logic                   blocked_seen;
    logic                   clear_answers[$];
    int                     mismatch_count;
    int                     answer_count;
    int                     blocked_count;

    function automatic logic path_blocked(coord_t ox, coord_t oy);
        logic signed [COORD_WIDTH:0]       dx;
        logic signed [COORD_WIDTH:0]       dy;
        logic signed [COORD_WIDTH:0]       rx;
        logic signed [COORD_WIDTH:0]       ry;
        logic signed [COORD_WIDTH-1:0]     reach;
        logic signed [2*COORD_WIDTH+2:0]   along;
        logic signed [2*COORD_WIDTH+2:0]   across;
        logic signed [2*COORD_WIDTH+2:0]   span;
        logic signed [4*COORD_WIDTH+7:0]   across_sq;
        logic signed [4*COORD_WIDTH+7:0]   limit;
        dx = finish_x - start_x;
        dy = finish_y - start_y;
        rx = ox - start_x;
        ry = oy - start_y;
        reach = {1'b0, clearance};
        along = rx * dx + ry * dy;
        across = rx * dy - ry * dx;
        span = dx * dx + dy * dy;
        across_sq = across * across;
        limit = reach * reach * span;
        return (along > 0) && (along < span) && (across_sq < limit);
    endfunction

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [MODE_W-1:0] mode;
        logic              want;
        if (!rst_n)
        begin
            start_x = '0;
            start_y = '0;
            finish_x = '0;
            finish_y = '0;
            clearance = '0;
            blocked_seen = 1'b0;
            clear_answers.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (cfg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_START_X:   start_x = pwdata[COORD_WIDTH-1:0];
                    REG_START_Y:   start_y = pwdata[COORD_WIDTH-1:0];
                    REG_FINISH_X:  finish_x = pwdata[COORD_WIDTH-1:0];
                    REG_FINISH_Y:  finish_y = pwdata[COORD_WIDTH-1:0];
                    REG_CLEARANCE: clearance = pwdata[COORD_WIDTH-2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                mode = s_tuser;
                if (mode == MODE_MORE || mode == MODE_LAST)
                begin
                    if (path_blocked(s_tdata[COORD_WIDTH-1:0],
                                     s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]))
                        blocked_seen = 1'b1;
                end
                if (mode != MODE_MORE)
                begin
                    clear_answers.insert(clear_answers.size(), !blocked_seen);
                    blocked_seen = 1'b0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (clear_answers.size() == 0)
                    report($sformatf("unexpected result word: path_clear %0b", m_tdata[0]));
                else
                begin
                    want = clear_answers.pop_front();
                    answer_count++;
                    if (!want)
                        blocked_count++;
                    if (m_tdata[0] !== want)
                        report($sformatf("path_clear mismatch: expected %0b, got %0b",
                                         want, m_tdata[0]));
                end
            end
            pending <= clear_answers.size();
        end
        failures <= mismatch_count;
        answers <= answer_count;
        blocked_answers <= blocked_count;
    end

endmodule

@@ test/segment_obstacle_clearance_unit_test.sv @@
// Stimulus and verdict for segment_obstacle_clearance_unit: programs paths over APB, streams
// obstacle lists with random gaps and stalls, and reads the checker's failure count.
// Depends on socu_pkg, the block and segment_obstacle_clearance_check.
module segment_obstacle_clearance_unit_test;

    import socu_pkg::*;

    localparam int COORD_W        = COORD_WIDTH_DEF;
    localparam int IN_W           = ((2*COORD_W+7)/8)*8;
    localparam int CMIN           = -(1 << (COORD_W-1));
    localparam int CMAX           = (1 << (COORD_W-1)) - 1;
    localparam int CLR_MAX        = (1 << (COORD_W-1)) - 1;
    localparam int PHASES         = 10;
    localparam int PHASE_WORDS    = 103;
    localparam int SETTLE_CYCLES  = 24;
    localparam int BACKLOG_AT     = 400;
    localparam int BACKLOG_CYCLES = 500;
    localparam int LIMIT_CYCLES   = 400000;

    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b1;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int   failures;
    int   pending;
    int   answers;
    int   blocked_answers;
    int   words_sent = 0;
    int   settings_used = 0;
    bit   steady = 1'b0;
    bit   backlog_done = 1'b0;
    int   path_sx;
    int   path_sy;
    int   path_fx;
    int   path_fy;
    int   path_clr;

    segment_obstacle_clearance_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    segment_obstacle_clearance_check clearance_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .failures        (failures),
        .pending         (pending),
        .answers         (answers),
        .blocked_answers (blocked_answers)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int rand_coord();
        return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < CMIN)
            return CMIN;
        if (v > CMAX)
            return CMAX;
        return v;
    endfunction

    // upper bits beyond the register width carry junk; the block must drop them
    function automatic logic [APB_DATA_W-1:0] with_junk(int v, int bits);
        logic [APB_DATA_W-1:0] keep;
        keep = (APB_DATA_W'(1) << bits) - 1;
        return ($urandom & ~keep) | (APB_DATA_W'(v) & keep);
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [APB_DATA_W-1:0] value);
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_path(int sx, int sy, int fx, int fy, int clr);
        path_sx = sx;
        path_sy = sy;
        path_fx = fx;
        path_fy = fy;
        path_clr = clr;
        write_reg(REG_START_X, with_junk(sx, COORD_W));
        write_reg(REG_START_Y, with_junk(sy, COORD_W));
        write_reg(REG_FINISH_X, with_junk(fx, COORD_W));
        write_reg(REG_FINISH_Y, with_junk(fy, COORD_W));
        write_reg(REG_CLEARANCE, with_junk(clr, COORD_W - 1));
        psel <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic send_word(logic [MODE_W-1:0] mode, int x, int y);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= IN_W'({coord_t'(y), coord_t'(x)});
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    // mostly points scattered around the segment and its corridor, the rest anywhere
    task automatic send_obstacle(logic [MODE_W-1:0] mode);
        int k;
        int spread;
        int ox;
        int oy;
        if ($urandom_range(0, 2) == 0)
        begin
            ox = rand_coord();
            oy = rand_coord();
        end
        else
        begin
            k = int'($urandom_range(0, 320)) - 32;
            spread = 2 * path_clr + 64;
            ox = path_sx + (path_fx - path_sx) * k / 256
                 + int'($urandom_range(0, 2 * spread)) - spread;
            oy = path_sy + (path_fy - path_sy) * k / 256
                 + int'($urandom_range(0, 2 * spread)) - spread;
        end
        send_word(mode, clamp_coord(ox), clamp_coord(oy));
    endtask

    task automatic send_query();
        send_word($urandom_range(0, 1) ? MODE_QUERY : MODE_SPARE, rand_coord(), rand_coord());
    endtask

    task automatic run_lists(int quota);
        int first;
        int shape;
        int n;
        int i;
        first = words_sent;
        while (words_sent - first < quota)
        begin
            shape = $urandom_range(0, 9);
            n = $urandom_range(1, 12);
            if (shape == 0)
                send_query();
            else
            begin
                for (i = 1; i < n; i++)
                    send_obstacle(MODE_MORE);
                if (shape == 1)
                    send_query();
                else
                    send_obstacle(MODE_LAST);
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!backlog_done && words_sent >= BACKLOG_AT)
            begin
                backlog_done = 1'b1;
                hold = BACKLOG_CYCLES;
            end
            else
                hold = steady ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        int w;
        int ax;
        int ay;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // path along +x, four units long, one unit of clearance
        set_path(0, 0, 16384, 0, 4096);
        send_word(MODE_QUERY, 0, 0);
        send_word(MODE_LAST, 8192, 0);
        send_word(MODE_LAST, 0, 0);
        send_word(MODE_LAST, 16384, 0);
        send_word(MODE_LAST, 8192, 4096);
        send_word(MODE_LAST, 8192, -4095);
        send_word(MODE_MORE, 8192, 0);
        send_word(MODE_MORE, CMIN, CMIN);
        send_word(MODE_LAST, CMAX, CMAX);
        send_word(MODE_MORE, 8192, 100);
        send_word(MODE_QUERY, CMAX, CMIN);
        send_word(MODE_QUERY, 0, 0);
        send_word(MODE_SPARE, CMIN, CMAX);
        send_word(MODE_MORE, CMIN, CMAX);
        send_word(MODE_LAST, CMAX, CMIN);
        send_word(MODE_MORE, 1, 0);
        send_word(MODE_LAST, 16383, 0);
        settle();

        for (w = 0; w < PHASES; w++)
        begin
            case (w)
                0: set_path(CMIN, CMIN, CMAX, CMAX, CLR_MAX);
                1:
                begin
                    ax = rand_coord();
                    ay = rand_coord();
                    set_path(ax, ay, ax, ay, $urandom_range(0, CLR_MAX));
                end
                2: set_path(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 0);
                3: set_path(CMAX, CMIN, CMIN, CMAX, $urandom_range(0, 8192));
                default:
                begin
                    ax = rand_coord();
                    ay = rand_coord();
                    set_path(ax, ay,
                             clamp_coord(ax + int'($urandom_range(0, 131072)) - 65536),
                             clamp_coord(ay + int'($urandom_range(0, 131072)) - 65536),
                             $urandom_range(0, 16384));
                end
            endcase
            steady = (w % 4 == 3);
            run_lists(PHASE_WORDS);
            settle();
        end

        $display("Covered %0d obstacle and query words over %0d path settings;",
                 words_sent, settings_used);
        $display("%0d clearance answers compared, %0d of them blocked.",
                 answers, blocked_answers);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_CYCLES * 20);
        $display("FAILURE");
        $finish;
    end

endmodule
